// ===== hdl/pfrm_pkg.sv =====
// Package for the pre-record frame ring manager.
// Holds defaults and result status codes; no dependencies.
package pfrm_pkg;
  localparam int FRAME_SLOTS_DEF = 128;
  localparam int BYTE_SPACE_DEF = 1048576;
  localparam logic [19:0] MAX_BYTES_RST = 20'd262144;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_POPPED  = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;
endpackage

// ===== hdl/prerecord_frame_ring_manager.sv =====
// Pre-record frame ring manager.
// Depends on pfrm_pkg; contains the descriptor memory and sequencer.
//
// Usage: raise start with kind and the frame fields while busy is low; the
// request is taken at that edge and busy rises. A push (kind 0) checks the
// length, evicts oldest frames when not recording, wraps to offset zero if the
// frame would cross the end of the byte ring and writes the descriptor. A pop
// (kind 1) reads the oldest descriptor and advances the read point.
// One result appears with done high for exactly one cycle; the receiver
// cannot stall it. A pop passes through the memory read, output, read of the
// next offset, advance and done states. A push checks, then per evicted frame
// reads and advances the read point and checks again, rechecks after a wrap,
// and ends in done; an empty pop or a bad length goes straight to done. The
// eviction step re-reads the new oldest offset from the descriptor memory
// through its single registered read port. A new request can be taken at the
// edge that ends the done cycle.
// max_frame_bytes is written via cfg_valid/cfg_ready while idle.
// Synchronous reset empties the ring and restores max_frame_bytes to 262144;
// descriptor memory is not cleared.
module prerecord_frame_ring_manager
  import pfrm_pkg::*;
#(
  parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
  parameter int BYTE_SPACE = BYTE_SPACE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [19:0] frame_length,
  input  logic        key_flag,
  input  logic        dispose_mark,
  input  logic [31:0] frame_stamp,
  input  logic        recording,
  output logic        done,
  output logic [2:0]  status,
  output logic [19:0] byte_offset,
  output logic [6:0]  slot_used,
  output logic [19:0] out_length,
  output logic        out_key,
  output logic        out_dispose,
  output logic [31:0] out_stamp,
  output logic [7:0]  frames_held,
  output logic [7:0]  evicted_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  localparam int SW = $clog2(FRAME_SLOTS);
  localparam int CW = SW + 1;
  localparam int BW = $clog2(BYTE_SPACE);
  localparam int BWW = BW + 1;
  localparam int GW = CW + 2;
  localparam logic [CW-1:0] NSLOT = CW'(FRAME_SLOTS);
  localparam logic [BWW-1:0] NBYTE = BWW'(BYTE_SPACE);
  localparam logic [GW-1:0] GUARD0 = GW'(2 * FRAME_SLOTS + 4);

  typedef enum logic [2:0] {
    S_IDLE, S_POPRD, S_POPADV, S_CHECK, S_EVRD, S_EVSET, S_DONE
  } state_t;
  state_t state;

  logic [BW-1:0] mem_off [FRAME_SLOTS];
  logic [19:0]   mem_len [FRAME_SLOTS];
  logic          mem_key [FRAME_SLOTS];
  logic          mem_dsp [FRAME_SLOTS];
  logic [31:0]   mem_stp [FRAME_SLOTS];

  logic [CW-1:0]  write_slot, wrap_slots;
  logic [SW-1:0]  read_slot;
  logic [BWW-1:0] write_byte;
  logic [BWW-1:0] read_byte;
  logic [19:0]    max_frame_bytes;
  logic [GW-1:0]  guard;

  logic        q_key, q_dsp, q_rec;
  logic [19:0] q_len;
  logic [31:0] q_stp;

  logic          we;
  logic [SW-1:0] waddr, raddr;
  logic [BW-1:0] rd_off;
  logic [19:0]   rd_len;
  logic          rd_key, rd_dsp;
  logic [31:0]   rd_stp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_off[waddr] <= write_byte[BW-1:0];
      mem_len[waddr] <= q_len;
      mem_key[waddr] <= q_key;
      mem_dsp[waddr] <= q_dsp;
      mem_stp[waddr] <= q_stp;
    end
    rd_off <= mem_off[raddr];
    rd_len <= mem_len[raddr];
    rd_key <= mem_key[raddr];
    rd_dsp <= mem_dsp[raddr];
    rd_stp <= mem_stp[raddr];
  end

  // derived ring quantities
  logic [CW-1:0]  held, slots_free, rs_next_w;
  logic [BWW-1:0] space_free;
  logic           need_room, need_wrap;
  logic [SW-1:0]  rs_next;
  logic [CW-1:0]  rs_inc;

  always_comb begin
    if (write_slot >= {1'b0, read_slot}) begin
      held = write_slot - {1'b0, read_slot};
      slots_free = NSLOT - write_slot + {1'b0, read_slot} - 1'b1;
    end else begin
      held = wrap_slots - {1'b0, read_slot} + write_slot;
      slots_free = {1'b0, read_slot} - write_slot - 1'b1;
    end
    // read point may sit at the very end of the byte ring
    if (read_byte == write_byte) space_free = NBYTE;
    else if (read_byte > write_byte)
      space_free = (read_byte - write_byte >= NBYTE) ? '0 : read_byte - write_byte;
    else space_free = NBYTE - write_byte + read_byte;
    need_room = (space_free < BWW'(q_len)) || (slots_free == '0);
    need_wrap = (write_slot >= NSLOT) || (BWW'(q_len) > NBYTE - write_byte);
    rs_inc = {1'b0, read_slot} + 1'b1;
    rs_next_w = (rs_inc >= wrap_slots) ? '0 : rs_inc;
    rs_next = rs_next_w[SW-1:0];
    we = (state == S_CHECK) && !need_room && !need_wrap;
    waddr = write_slot[SW-1:0];
    raddr = (state == S_IDLE || state == S_POPRD) ? read_slot : rs_next;
  end

  assign busy = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !start;
  assign frames_held = 8'(held);

  logic [7:0] evn;
  logic [BWW-1:0] wb_new;
  assign wb_new = write_byte + BWW'(q_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      write_slot <= '0;
      read_slot <= '0;
      write_byte <= '0;
      read_byte <= '0;
      wrap_slots <= NSLOT;
      max_frame_bytes <= MAX_BYTES_RST;
      done <= 1'b0;
      guard <= '0;
      evn <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) max_frame_bytes <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            q_len <= frame_length;
            q_key <= key_flag;
            q_dsp <= dispose_mark;
            q_stp <= frame_stamp;
            q_rec <= recording;
            evn <= '0;
            guard <= GUARD0;
            status <= ST_STORED;
            byte_offset <= '0;
            slot_used <= '0;
            out_key <= 1'b0;
            out_dispose <= 1'b0;
            out_stamp <= '0;
            if (kind) begin
              out_length <= '0;
              if (held == '0) begin
                status <= ST_EMPTY;
                state <= S_DONE;
              end else state <= S_POPRD;
            end else begin
              out_length <= frame_length;
              if (frame_length == '0 || frame_length > max_frame_bytes ||
                  BWW'(frame_length) > NBYTE) begin
                status <= ST_BADLEN;
                state <= S_DONE;
              end else state <= S_CHECK;
            end
          end
        end
        S_POPRD: state <= S_POPADV;
        S_POPADV: begin
          status <= ST_POPPED;
          byte_offset <= 20'(rd_off);
          slot_used <= 7'(read_slot);
          out_length <= rd_len;
          out_key <= rd_key;
          out_dispose <= rd_dsp;
          out_stamp <= rd_stp;
          state <= S_EVRD;
        end
        S_CHECK: begin
          if (need_room) begin
            if (q_rec || held == '0 || guard == '0) begin
              status <= ST_DROPPED;
              state <= S_DONE;
            end else begin
              guard <= guard - 1'b1;
              evn <= evn + 1'b1;
              state <= S_EVRD;
            end
          end else if (need_wrap) begin
            wrap_slots <= write_slot;
            write_slot <= '0;
            write_byte <= '0;
          end else begin
            status <= ST_STORED;
            byte_offset <= 20'(write_byte);
            slot_used <= 7'(waddr);
            write_slot <= write_slot + 1'b1;
            write_byte <= wb_new;
            if (q_key && !q_rec) begin
              read_byte <= write_byte;
              read_slot <= waddr;
            end
            if (write_slot + 1'b1 > wrap_slots) wrap_slots <= write_slot + 1'b1;
            state <= S_DONE;
          end
        end
        S_EVRD: state <= S_EVSET;
        S_EVSET: begin
          read_slot <= rs_next;
          if (write_slot != {1'b0, rs_next} &&
              !(write_slot >= wrap_slots && rs_next == '0 && write_slot == '0))
            read_byte <= {1'b0, rd_off};
          else read_byte <= write_byte;
          state <= (status == ST_POPPED) ? S_DONE : S_CHECK;
        end
        S_DONE: begin
          done <= 1'b1;
          evicted_count <= evn;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/pfrm_checker.sv =====
// Port-level checker for the pre-record frame ring manager.
// Depends on pfrm_pkg; bound to prerecord_frame_ring_manager.
module pfrm_checker
  import pfrm_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [2:0] status,
  input logic [7:0] frames_held,
  input logic [7:0] evicted_count
);
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_EMPTY) else $error("bad status");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_EMPTY |-> frames_held == 8'd0) else $error("empty mismatch");
  a_pop_evict: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_POPPED |-> evicted_count == 8'd0) else $error("pop evicted");
endmodule

bind prerecord_frame_ring_manager pfrm_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .frames_held(frames_held), .evicted_count(evicted_count)
);
